>>> hw/rtl/imhq_pkg.sv
package imhq_pkg;

    localparam int MaxNodes = 256;
    localparam int KeyBits  = 32;
    localparam int IdBits   = $clog2(MaxNodes);
    localparam int SlotBits = $clog2(MaxNodes + 1);

    typedef logic [IdBits-1:0]   id_t;
    typedef logic [SlotBits-1:0] slot_t;
    typedef logic [KeyBits-1:0]  key_t;

    localparam key_t KeyInf = {KeyBits{1'b1}};

    typedef enum logic [1:0] {
        OP_INIT    = 2'd0,
        OP_EXTRACT = 2'd1,
        OP_DECR    = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_ABSENT   = 2'd2,
        ST_NOT_LESS = 2'd3
    } status_t;

    localparam logic CfgNodeCount  = 1'b0;
    localparam logic CfgSourceNode = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CLEAR,
        S_LOAD,
        S_EX_RD,
        S_EX_RD2,
        S_EX_WR,
        S_DN_RD,
        S_DN_K1,
        S_DN_K2,
        S_DN_CMP,
        S_DN_SW,
        S_DK_RD,
        S_DK_CHK,
        S_UP_RD,
        S_UP_K,
        S_UP_CMP,
        S_UP_SW,
        S_DONE
    } state_t;

endpackage

>>> hw/rtl/imhq_in_if.sv
interface imhq_in_if;
    import imhq_pkg::*;
    logic  valid;
    logic  ready;
    op_t   op;
    id_t   node_id;
    key_t  new_key;
    modport source (output valid, op, node_id, new_key, input ready);
    modport sink (input valid, op, node_id, new_key, output ready);
endinterface

>>> hw/rtl/imhq_out_if.sv
interface imhq_out_if;
    import imhq_pkg::*;
    logic    valid;
    logic    ready;
    id_t     result_node;
    key_t    result_key;
    status_t status;
    slot_t   queued_count;
    modport source (output valid, result_node, result_key, status, queued_count,
                    input ready);
    modport sink (input valid, result_node, result_key, status, queued_count,
                  output ready);
endinterface

>>> hw/rtl/imhq_ram.sv
module imhq_ram #(
    parameter int Width = 8,
    parameter int Depth = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> hw/rtl/indexed_min_heap_queue.sv
// Channel | Dir | Payload
// in      | in  | op, node_id, new_key
// out     | out | result_node, result_key, status, queued_count
// cfg     | in  | cfg_we, cfg_index, cfg_data (node_count, source_node)
//
// One transaction at a time. Init clears the position map and then loads
// node_count ids, clamped to 256. Extract and decrease-key sift through up to
// 8 levels; each level reads the slot and key memories and writes the slot and
// position memories.
// Reset clears control state only; heap, key and position memories are undefined until
// written. Until the first init every node reads as not queued, and that init
// clears the position map.
// A result waits in the output register; the next item is taken once it leaves.
module indexed_min_heap_queue
    import imhq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    imhq_in_if.sink     in_ch,
    imhq_out_if.source  out_ch,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [8:0]  cfg_data
);
    state_t state_reg, state_next;
    slot_t  ncount_reg, ncount_next;
    id_t    src_reg, src_next;
    slot_t  live_reg, live_next;
    slot_t  s_reg, s_next;
    slot_t  b_reg, b_next;
    slot_t  cnt_reg, cnt_next;
    id_t    ida_reg, ida_next;
    id_t    idb_reg, idb_next;
    id_t    idc_reg, idc_next;
    key_t   ka_reg, ka_next;
    key_t   kb_reg, kb_next;
    key_t   nk_reg, nk_next;
    logic   pos_ok_reg, pos_ok_next;
    logic   ovalid_reg, ovalid_next;
    logic   loaded_reg, loaded_next;
    id_t    rnode_reg, rnode_next;
    key_t   rkey_reg, rkey_next;
    status_t rstat_reg, rstat_next;

    // memories
    logic   h_we;  id_t h_wa, h_ra; id_t h_wd, h_rd;
    logic   k_we;  id_t k_wa, k_ra; key_t k_wd, k_rd;
    logic   p_we;  id_t p_wa, p_ra; slot_t p_wd, p_rd;

    imhq_ram #(.Width(IdBits), .Depth(MaxNodes)) u_heap (
        .clk(clk), .we(h_we), .waddr(h_wa), .wdata(h_wd), .raddr(h_ra), .rdata(h_rd));
    imhq_ram #(.Width(KeyBits), .Depth(MaxNodes)) u_key (
        .clk(clk), .we(k_we), .waddr(k_wa), .wdata(k_wd), .raddr(k_ra), .rdata(k_rd));
    imhq_ram #(.Width(SlotBits), .Depth(MaxNodes)) u_pos (
        .clk(clk), .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(p_ra), .rdata(p_rd));

    slot_t n_clamp;
    logic  src_in;
    slot_t lc, rc;
    assign n_clamp = (ncount_reg > slot_t'(MaxNodes)) ? slot_t'(MaxNodes) : ncount_reg;
    assign src_in  = slot_t'(src_reg) < n_clamp;
    assign lc      = slot_t'({s_reg, 1'b0});
    assign rc      = lc + slot_t'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ncount_reg <= slot_t'(1);
            src_reg    <= '0;
            live_reg   <= '0;
            ovalid_reg <= 1'b0;
            loaded_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ncount_reg <= ncount_next;
            src_reg    <= src_next;
            live_reg   <= live_next;
            ovalid_reg <= ovalid_next;
            loaded_reg <= loaded_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg      <= s_next;
        b_reg      <= b_next;
        cnt_reg    <= cnt_next;
        ida_reg    <= ida_next;
        idb_reg    <= idb_next;
        idc_reg    <= idc_next;
        ka_reg     <= ka_next;
        kb_reg     <= kb_next;
        nk_reg     <= nk_next;
        pos_ok_reg <= pos_ok_next;
        rnode_reg  <= rnode_next;
        rkey_reg   <= rkey_next;
        rstat_reg  <= rstat_next;
    end

    assign in_ch.ready         = (state_reg == S_IDLE) && !ovalid_reg;
    assign out_ch.valid        = ovalid_reg;
    assign out_ch.result_node  = rnode_reg;
    assign out_ch.result_key   = rkey_reg;
    assign out_ch.status       = rstat_reg;
    assign out_ch.queued_count = live_reg;

    always_comb
    begin
        state_next  = state_reg;
        ncount_next = ncount_reg;
        src_next    = src_reg;
        live_next   = live_reg;
        s_next      = s_reg;
        b_next      = b_reg;
        cnt_next    = cnt_reg;
        ida_next    = ida_reg;
        idb_next    = idb_reg;
        idc_next    = idc_reg;
        ka_next     = ka_reg;
        kb_next     = kb_reg;
        nk_next     = nk_reg;
        pos_ok_next = pos_ok_reg;
        ovalid_next = ovalid_reg;
        loaded_next = loaded_reg;
        rnode_next  = rnode_reg;
        rkey_next   = rkey_reg;
        rstat_next  = rstat_reg;
        h_we = 1'b0; h_wa = '0; h_wd = '0; h_ra = '0;
        k_we = 1'b0; k_wa = '0; k_wd = '0; k_ra = '0;
        p_we = 1'b0; p_wa = '0; p_wd = '0; p_ra = '0;

        if (ovalid_reg && out_ch.ready)
        begin
            ovalid_next = 1'b0;
        end

        if (cfg_we)
        begin
            if (cfg_index == CfgNodeCount)
            begin
                ncount_next = cfg_data;
            end
            else
            begin
                src_next = cfg_data[IdBits-1:0];
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid && !ovalid_reg)
                begin
                    rnode_next = '0;
                    rkey_next  = '0;
                    rstat_next = ST_OK;
                    nk_next    = in_ch.new_key;
                    ida_next   = in_ch.node_id;
                    cnt_next   = '0;
                    unique case (in_ch.op)
                        OP_INIT:    state_next = S_CLEAR;
                        OP_EXTRACT:
                        begin
                            if (live_reg == '0)
                            begin
                                rstat_next = ST_EMPTY;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                h_ra       = '0;
                                state_next = S_EX_RD;
                            end
                        end
                        OP_DECR:
                        begin
                            p_ra       = in_ch.node_id;
                            k_ra       = in_ch.node_id;
                            state_next = S_DK_RD;
                        end
                        default:    state_next = S_DONE;
                    endcase
                end
            end
            S_CLEAR:
            begin
                p_we     = 1'b1;
                p_wa     = cnt_reg[IdBits-1:0];
                p_wd     = '0;
                cnt_next = cnt_reg + slot_t'(1);
                if (cnt_reg == slot_t'(MaxNodes - 1))
                begin
                    cnt_next    = '0;
                    s_next      = slot_t'(1);
                    live_next   = n_clamp;
                    loaded_next = 1'b1;
                    state_next  = (n_clamp == '0) ? S_DONE : S_LOAD;
                    if (src_in)
                    begin
                        // The source goes to the root first.
                        h_we = 1'b1; h_wa = '0; h_wd = src_reg;
                        k_we = 1'b1; k_wa = src_reg; k_wd = '0;
                        s_next = slot_t'(2);
                    end
                end
            end
            S_LOAD:
            begin
                // cnt_reg walks the ids; s_reg is the next free 1-based slot.
                if (src_in && cnt_reg == slot_t'(src_reg))
                begin
                    p_we = 1'b1; p_wa = src_reg; p_wd = slot_t'(1);
                end
                else
                begin
                    h_we = 1'b1; h_wa = id_t'(s_reg - slot_t'(1));
                    h_wd = cnt_reg[IdBits-1:0];
                    k_we = 1'b1; k_wa = cnt_reg[IdBits-1:0]; k_wd = KeyInf;
                    p_we = 1'b1; p_wa = cnt_reg[IdBits-1:0]; p_wd = s_reg;
                    s_next = s_reg + slot_t'(1);
                end
                cnt_next = cnt_reg + slot_t'(1);
                if (cnt_reg + slot_t'(1) == n_clamp)
                begin
                    state_next = S_DONE;
                end
            end
            S_EX_RD:
            begin
                ida_next   = h_rd;
                k_ra       = h_rd;
                h_ra       = id_t'(live_reg - slot_t'(1));
                state_next = S_EX_RD2;
            end
            S_EX_RD2:
            begin
                rnode_next = ida_reg;
                rkey_next  = k_rd;
                idb_next   = h_rd;
                state_next = S_EX_WR;
            end
            S_EX_WR:
            begin
                h_we = 1'b1; h_wa = '0; h_wd = idb_reg;
                p_we = 1'b1; p_wa = idb_reg; p_wd = slot_t'(1);
                live_next = live_reg - slot_t'(1);
                s_next    = slot_t'(1);
                if (idb_reg == ida_reg)
                begin
                    p_wd = '0;
                end
                state_next = S_DN_RD;
            end
            S_DN_RD:
            begin
                // The moved id travels down; remove the extracted id afterwards.
                if (ida_reg != idb_reg)
                begin
                    p_we = 1'b1; p_wa = ida_reg; p_wd = '0;
                    ida_next = idb_reg;
                end
                if (lc > live_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    h_ra       = id_t'(lc - slot_t'(1));
                    k_ra       = (ida_reg != idb_reg) ? idb_reg : ida_reg;
                    state_next = S_DN_K1;
                end
            end
            S_DN_K1:
            begin
                ka_next    = k_rd;
                k_ra       = h_rd;
                idb_next   = h_rd;
                b_next     = lc;
                h_ra       = id_t'(rc - slot_t'(1));
                state_next = S_DN_K2;
            end
            S_DN_K2:
            begin
                if (k_rd < ka_reg)
                begin
                    ka_next = k_rd;
                end
                else
                begin
                    b_next   = s_reg;
                    idb_next = ida_reg;
                end
                idc_next   = h_rd;
                k_ra       = h_rd;
                state_next = (rc <= live_reg) ? S_DN_CMP : S_DN_SW;
            end
            S_DN_CMP:
            begin
                if (k_rd < ka_reg)
                begin
                    b_next   = rc;
                    idb_next = idc_reg;
                end
                state_next = S_DN_SW;
            end
            S_DN_SW:
            begin
                if (b_reg == s_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    h_we = 1'b1; h_wa = id_t'(s_reg - slot_t'(1)); h_wd = idb_reg;
                    p_we = 1'b1; p_wa = idb_reg; p_wd = s_reg;
                    s_next     = b_reg;
                    state_next = S_UP_SW;
                    pos_ok_next = 1'b0;
                end
            end
            S_DK_RD:
            begin
                if (!loaded_reg || p_rd == '0)
                begin
                    rstat_next = ST_ABSENT;
                    state_next = S_DONE;
                end
                else if (nk_reg >= k_rd)
                begin
                    rstat_next = ST_NOT_LESS;
                    state_next = S_DONE;
                end
                else
                begin
                    k_we = 1'b1; k_wa = ida_reg; k_wd = nk_reg;
                    s_next     = p_rd;
                    state_next = S_DK_CHK;
                end
            end
            S_DK_CHK:
            begin
                if (s_reg == slot_t'(1))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    h_ra       = id_t'((s_reg >> 1) - slot_t'(1));
                    state_next = S_UP_RD;
                end
            end
            S_UP_RD:
            begin
                idb_next   = h_rd;
                k_ra       = h_rd;
                state_next = S_UP_K;
            end
            S_UP_K:
            begin
                state_next = S_UP_CMP;
                kb_next    = k_rd;
            end
            S_UP_CMP:
            begin
                if (kb_reg > nk_reg)
                begin
                    h_we = 1'b1; h_wa = id_t'(s_reg - slot_t'(1)); h_wd = idb_reg;
                    p_we = 1'b1; p_wa = idb_reg; p_wd = s_reg;
                    s_next      = s_reg >> 1;
                    pos_ok_next = 1'b1;
                    state_next  = S_UP_SW;
                end
                else
                begin
                    h_we = 1'b1; h_wa = id_t'(s_reg - slot_t'(1)); h_wd = ida_reg;
                    p_we = 1'b1; p_wa = ida_reg; p_wd = s_reg;
                    state_next = S_DONE;
                end
            end
            S_UP_SW:
            begin
                // Shared step: place the travelling id at its new slot, then
                // continue up (decrease) or down (extract).
                h_we = 1'b1; h_wa = id_t'(s_reg - slot_t'(1)); h_wd = ida_reg;
                p_we = 1'b1; p_wa = ida_reg; p_wd = s_reg;
                if (pos_ok_reg)
                begin
                    state_next = S_DK_CHK;
                end
                else
                begin
                    idb_next   = ida_reg;
                    state_next = S_DN_RD;
                end
            end
            S_DONE:
            begin
                ovalid_next = 1'b1;
                state_next  = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> state_reg == S_IDLE)
        else $error("ready outside idle");
    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg <= slot_t'(MaxNodes))
        else $error("live count out of range");
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.status != ST_OK) |-> out_ch.result_node == '0)
        else $error("node on failed op");
    a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE |=> out_ch.valid)
        else $error("result lost");
endmodule
